[hw/rtl/qrbk_pkg.sv]
// shared types and constants for the keyed removal queue
// no dependencies; used by qrbk_cell and queue_remove_by_key
`timescale 1ns / 1ps

package qrbk_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // per-request commands broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic ins;
    logic rmv;
  } ctl_t;

endpackage

[hw/rtl/qrbk_cell.sv]
// one queue slot: key register, match flag, shift from the neighbour behind
// depends on qrbk_pkg
`timescale 1ns / 1ps

module qrbk_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qrbk_pkg::ctl_t              ctl,
  input  logic [CNT_W-1:0]            count,
  input  logic [qrbk_pkg::POS_W-1:0]  pos,
  input  logic [qrbk_pkg::KEY_W-1:0]  key,
  input  logic [qrbk_pkg::KEY_W-1:0]  next_entry,
  input  logic                        seen_in,
  output logic                        seen_out,
  input  logic [qrbk_pkg::KEY_W-1:0]  rd_in,
  output logic [qrbk_pkg::KEY_W-1:0]  rd_out,
  output logic [qrbk_pkg::KEY_W-1:0]  entry
);

  logic [qrbk_pkg::KEY_W-1:0] entry_r;
  logic                       hit_r;
  logic                       hit_nxt;
  logic                       valid;
  logic                       tail;
  logic                       sel;

  assign valid = IDX < int'(count);
  assign tail  = IDX == int'(count);
  assign sel   = IDX == int'(pos);

  assign hit_nxt  = ctl.cmp ? (valid && (entry_r == key)) : hit_r;
  // first match ahead of or at this slot: everything from here moves up
  assign seen_out = seen_in | hit_r;
  assign rd_out   = rd_in | (sel ? entry_r : '0);
  assign entry    = entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && tail) begin
      entry_r <= key;
    end else if (ctl.rmv && seen_out) begin
      entry_r <= next_entry;
    end
  end

endmodule

[hw/rtl/queue_remove_by_key.sv]
// ordered key queue with delete-by-key, built as a row of qrbk_cell slots
// requests are taken only in idle, not while busy; out_valid is registered
// from execute; accepting registers the per-slot key compare or fills the
// tail slot, execute ripples the match along the row and shifts
// reset: synchronous, empty queue; slot contents stay undefined until written
// the receiver cannot stall: out_valid is high for one cycle per request
`timescale 1ns / 1ps

module queue_remove_by_key #(
  parameter int DEPTH = qrbk_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic signed [qrbk_pkg::KEY_W-1:0] in_key,
  input  logic [qrbk_pkg::POS_W-1:0]    in_position,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic signed [qrbk_pkg::KEY_W-1:0] out_value,
  output logic [qrbk_pkg::CNT_OUT_W-1:0] out_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KW    = qrbk_pkg::KEY_W;

  qrbk_pkg::state_t state_r, state_nxt;
  qrbk_pkg::op_t    op_r;
  qrbk_pkg::ctl_t   ctl;

  logic [KW-1:0]                 key_r;
  logic [qrbk_pkg::POS_W-1:0]    pos_r;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          acc;
  logic                          found;

  logic                          out_valid_r;
  qrbk_pkg::status_t             status_r, status_nxt;
  logic [KW-1:0]                 value_r, value_nxt;
  logic [qrbk_pkg::CNT_OUT_W-1:0] ocount_r;

  logic [KW-1:0] ent [DEPTH];
  logic [KW-1:0] rd  [DEPTH+1];
  logic          seen [DEPTH+1];
  logic [KW-1:0] cell_key;
  logic [qrbk_pkg::POS_W-1:0] cell_pos;

  assign acc      = start && (state_r == qrbk_pkg::S_IDLE);
  // compare and insert use the incoming key, removal shifts after the latch
  assign cell_key = acc ? in_key : key_r;
  assign cell_pos = pos_r;
  assign seen[0]  = 1'b0;
  assign rd[0]    = '0;
  assign found    = seen[DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KW-1:0] nxt_ent;
      if (gi < DEPTH - 1) begin : g_mid
        assign nxt_ent = ent[gi+1];
      end else begin : g_last
        assign nxt_ent = '0;
      end
      qrbk_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .count      (count_r),
        .pos        (cell_pos),
        .key        (cell_key),
        .next_entry (nxt_ent),
        .seen_in    (seen[gi]),
        .seen_out   (seen[gi+1]),
        .rd_in      (rd[gi]),
        .rd_out     (rd[gi+1]),
        .entry      (ent[gi])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      qrbk_pkg::S_IDLE: if (start) state_nxt = qrbk_pkg::S_EXEC;
      qrbk_pkg::S_EXEC: state_nxt = qrbk_pkg::S_IDLE;
      default:          state_nxt = qrbk_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy    = 1'b0;
    ctl.cmp = 1'b0;
    ctl.ins = 1'b0;
    ctl.rmv = 1'b0;
    unique case (state_r)
      qrbk_pkg::S_IDLE: begin
        ctl.cmp = start && (in_opcode == qrbk_pkg::OP_REMOVE);
        ctl.ins = start && (in_opcode == qrbk_pkg::OP_INSERT);
      end
      qrbk_pkg::S_EXEC: begin
        busy    = 1'b1;
        ctl.rmv = (op_r == qrbk_pkg::OP_REMOVE);
      end
      default: busy = 1'b0;
    endcase
  end

  // result of the request in flight
  always_comb begin
    status_nxt = qrbk_pkg::ST_OK;
    value_nxt  = '0;
    count_nxt  = count_r;
    if (state_r == qrbk_pkg::S_EXEC) begin
      unique case (op_r)
        qrbk_pkg::OP_INSERT: begin
          if (count_r < CNT_W'(DEPTH)) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            status_nxt = qrbk_pkg::ST_FULL;
          end
        end
        qrbk_pkg::OP_REMOVE: begin
          if (found) begin
            count_nxt = count_r - CNT_W'(1);
            value_nxt = key_r;
          end else begin
            status_nxt = qrbk_pkg::ST_NOT_FOUND;
          end
        end
        qrbk_pkg::OP_READ: begin
          if (int'(pos_r) < int'(count_r)) begin
            value_nxt = rd[DEPTH];
          end else begin
            status_nxt = qrbk_pkg::ST_RANGE;
          end
        end
        default: status_nxt = qrbk_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qrbk_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == qrbk_pkg::S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r  <= qrbk_pkg::op_t'(in_opcode);
      key_r <= in_key;
      pos_r <= in_position;
    end
    if (state_r == qrbk_pkg::S_EXEC) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      ocount_r <= qrbk_pkg::CNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_value  = value_r;
  assign out_count  = ocount_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= DEPTH)
    else $error("occupancy above depth");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == qrbk_pkg::S_EXEC |=> state_r == qrbk_pkg::S_IDLE)
    else $error("execute phase longer than one cycle");

  a_strobe_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == qrbk_pkg::S_EXEC))
    else $error("result strobe without a request");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qrbk_pkg::S_EXEC && op_r == qrbk_pkg::OP_REMOVE && found)
    |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("removal did not shrink the queue");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qrbk_pkg::S_EXEC && op_r == qrbk_pkg::OP_INSERT
     && count_r == CNT_W'(DEPTH)) |=> $stable(count_r))
    else $error("insert into a full queue changed occupancy");

endmodule
